// ----- design/csfr_pkg.sv -----
package csfr_pkg;

  localparam logic [7:0]  START_BYTE     = 8'hA5;
  localparam logic [9:0]  HEADER_LEN     = 10'd8;
  localparam logic [9:0]  DATA_OVERHEAD  = 10'd10;
  localparam logic [9:0]  CODE_POS       = 10'd3;
  localparam logic [9:0]  WORD_COUNT_POS = 10'd5;
  localparam logic [15:0] POLY_RESET     = 16'h1021;

  localparam logic [7:0] CODE_INCOMPLETE = 8'h02;
  localparam logic [7:0] CODE_INVALID    = 8'h04;
  localparam logic [7:0] CODE_DENIED     = 8'h06;
  localparam logic [7:0] CODE_FRAMING    = 8'h08;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_INCOMPLETE = 3'd1,
    STATUS_INVALID    = 3'd2,
    STATUS_DENIED     = 3'd3,
    STATUS_FRAMING    = 3'd4,
    STATUS_CRC_BAD    = 3'd5
  } status_t;

  typedef logic [7:0]  byte_t;
  typedef logic [9:0]  count_t;
  typedef logic [15:0] crc_t;

  // word held in the input register
  typedef struct packed {
    logic  valid;
    byte_t data;
  } item_t;

endpackage

// ----- design/csfr_if.sv -----
interface csfr_rx_if;
  import csfr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface csfr_frame_if;
  import csfr_pkg::*;

  logic   valid;
  logic   ready;
  byte_t  frame_byte;
  count_t byte_index;
  logic   frame_last;
  logic [2:0] frame_status;
  count_t frame_length;

  modport source (
    output valid, output frame_byte, output byte_index, output frame_last,
    output frame_status, output frame_length, input ready
  );
  modport sink (
    input valid, input frame_byte, input byte_index, input frame_last,
    input frame_status, input frame_length, output ready
  );
endinterface

// ----- design/csfr_in_reg.sv -----
module csfr_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  csfr_pkg::byte_t in_data,
  output logic            in_ready,
  input  logic            take,
  output csfr_pkg::item_t item
);
  import csfr_pkg::*;

  logic  valid;
  byte_t data;

  assign in_ready   = !valid || take;
  assign item.valid = valid;
  assign item.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

// ----- design/csfr_crc_byte.sv -----
module csfr_crc_byte (
  input  csfr_pkg::crc_t  crc_in,
  input  csfr_pkg::byte_t data,
  input  csfr_pkg::crc_t  poly,
  output csfr_pkg::crc_t  crc_out
);
  import csfr_pkg::*;

  // msb-first, one bit per step
  always_comb begin
    crc_t c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- design/csfr_frame_core.sv -----
module csfr_frame_core (
  input  logic            clk,
  input  logic            rst,
  input  csfr_pkg::item_t item,
  output logic            take,
  input  csfr_pkg::crc_t  poly,
  csfr_frame_if.source    frame
);
  import csfr_pkg::*;

  logic   in_frame;
  count_t byte_count;
  count_t expected_length;
  crc_t   crc_acc;
  byte_t  reported_code;

  logic   out_valid;
  byte_t  out_byte;
  count_t out_index;
  logic   out_last;
  logic [2:0] out_status;
  count_t out_length;

  logic    active;
  logic    fire;
  count_t  idx;
  count_t  count;
  crc_t    crc_in;
  crc_t    crc_next;
  byte_t   code_next;
  count_t  exp_next;
  logic    last;
  status_t status;

  assign take   = !out_valid || frame.ready;
  assign active = in_frame || (item.data == START_BYTE);
  assign fire   = item.valid && take;

  assign idx    = in_frame ? byte_count : '0;
  assign crc_in = in_frame ? crc_acc : '0;
  assign count  = idx + 10'd1;

  csfr_crc_byte u_crc (
    .crc_in  (crc_in),
    .data    (item.data),
    .poly    (poly),
    .crc_out (crc_next)
  );

  always_comb begin
    code_next = in_frame ? reported_code : 8'h00;
    if (idx == CODE_POS) begin
      code_next = item.data;
    end
    exp_next = in_frame ? expected_length : HEADER_LEN;
    if (idx == WORD_COUNT_POS && item.data != 8'h00) begin
      exp_next = {1'b0, item.data, 1'b0} + DATA_OVERHEAD;
    end
    last = (count >= exp_next);
  end

  always_comb begin
    priority if (code_next == CODE_INCOMPLETE) begin
      status = STATUS_INCOMPLETE;
    end else if (code_next == CODE_INVALID) begin
      status = STATUS_INVALID;
    end else if (code_next == CODE_DENIED) begin
      status = STATUS_DENIED;
    end else if (code_next == CODE_FRAMING) begin
      status = STATUS_FRAMING;
    end else if (crc_next != 16'h0000) begin
      status = STATUS_CRC_BAD;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_count      <= '0;
      expected_length <= HEADER_LEN;
      crc_acc         <= '0;
      reported_code   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (fire && active) begin
        if (last) begin
          in_frame        <= 1'b0;
          byte_count      <= '0;
          expected_length <= HEADER_LEN;
          crc_acc         <= '0;
          reported_code   <= '0;
        end else begin
          in_frame        <= 1'b1;
          byte_count      <= count;
          expected_length <= exp_next;
          crc_acc         <= crc_next;
          reported_code   <= code_next;
        end
      end
      if (take) begin
        out_valid <= fire && active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && active) begin
      out_byte   <= item.data;
      out_index  <= idx;
      out_last   <= last;
      out_status <= last ? status : STATUS_OK;
      out_length <= last ? count : '0;
    end
  end

  assign frame.valid        = out_valid;
  assign frame.frame_byte   = out_byte;
  assign frame.byte_index   = out_index;
  assign frame.frame_last   = out_last;
  assign frame.frame_status = out_status;
  assign frame.frame_length = out_length;

endmodule

// ----- design/crc_serial_frame_receiver.sv -----
// Serial frame receiver: bytes arrive on rx one word at a time and are dropped
// until the start byte 0xA5 opens a frame. Every frame byte, start byte
// included, leaves on frame with its index; the frame is 8 bytes long, or
// 2*n+10 when header byte 5 carries a non-zero word count n. On the final
// byte frame_last is high and frame_length and frame_status are filled in:
// an error code reported in header byte 3 wins, else a non-zero CRC-16
// residue (msb-first, zero start, polynomial from cfg_wr_data, reset 0x1021)
// flags a bad frame. One word is taken per clock while the output is not
// stalled; an accepted byte passes through the input register, then the
// byte-wide CRC and frame counter logic into the result register. Write the
// polynomial only while the block is idle.
module crc_serial_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  csfr_rx_if.sink     rx,
  csfr_frame_if.source frame,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import csfr_pkg::*;

  crc_t  poly;
  item_t item;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= POLY_RESET;
    end else if (cfg_wr_en) begin
      poly <= cfg_wr_data;
    end
  end

  csfr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_data  (rx.rx_byte),
    .in_ready (rx.ready),
    .take     (take),
    .item     (item)
  );

  csfr_frame_core u_core (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .take  (take),
    .poly  (poly),
    .frame (frame)
  );

endmodule

// ----- design/csfr_checker.sv -----
module csfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [9:0] out_index,
  input logic       out_last,
  input logic [2:0] out_status,
  input logic [9:0] out_length
);
  import csfr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_index))
    else $error("output word changed while stalled");

  a_last_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_length == out_index + 10'd1)
    else $error("frame length does not match index of last byte");

  a_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_status == STATUS_OK && out_length == 10'd0)
    else $error("status or length set on a byte that is not last");

  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_index == 10'd0 |-> out_byte == START_BYTE)
    else $error("frame does not open with the start byte");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind crc_serial_frame_receiver csfr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (frame.valid),
  .out_ready  (frame.ready),
  .out_byte   (frame.frame_byte),
  .out_index  (frame.byte_index),
  .out_last   (frame.frame_last),
  .out_status (frame.frame_status),
  .out_length (frame.frame_length)
);
